// ===== rtl/btfc_pkg.sv =====
// Shared types and codes for the backlight timeout and fade controller.
// No dependencies; imported by btfc_core and the top level.
package btfc_pkg;

  // request codes
  localparam logic [3:0] REQ_PRESS     = 4'd0;
  localparam logic [3:0] REQ_RELEASE   = 4'd1;
  localparam logic [3:0] REQ_INTERACT  = 4'd2;
  localparam logic [3:0] REQ_FORCE     = 4'd3;
  localparam logic [3:0] REQ_RESPECT   = 4'd4;
  localparam logic [3:0] REQ_RST_USER  = 4'd5;
  localparam logic [3:0] REQ_RST_TIMED = 4'd6;
  localparam logic [3:0] REQ_TGL_EN    = 4'd7;
  localparam logic [3:0] REQ_TGL_AMB   = 4'd8;
  localparam logic [3:0] REQ_PERMIT    = 4'd9;
  localparam logic [3:0] REQ_TICK      = 4'd10;
  localparam logic [3:0] REQ_SAMPLE    = 4'd11;

  // light modes
  localparam logic [1:0] MODE_OFF    = 2'd0;
  localparam logic [1:0] MODE_ON     = 2'd1;
  localparam logic [1:0] MODE_TIMED  = 2'd2;
  localparam logic [1:0] MODE_FADING = 2'd3;

  // config register indexes
  localparam logic [1:0] CFG_USER_LEVEL = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT_MS = 2'd1;
  localparam logic [1:0] CFG_DYNAMIC_ON = 2'd2;
  localparam logic [1:0] CFG_DARK_LIMIT = 2'd3;

  typedef struct packed {
    logic [15:0] user_level;
    logic [15:0] timeout_ms;
    logic        dynamic_on;
    logic [15:0] dark_limit;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  req_type;
    logic        flag_bit;
    logic [15:0] als_level;
    logic        is_bright;
    logic        power_save;
  } req_t;

  typedef struct packed {
    logic [15:0] level;
    logic [1:0]  mode;
  } res_t;

endpackage

// ===== rtl/backlight_timeout_fade_controller.sv =====
// Backlight timeout and fade controller, top level. Uses btfc_pkg, btfc_core, btfc_pct.
// Three register stages: input word, event result, output word with percent.
// An accepted word moves from the input register to the event result register, then to the output register.
// One word per cycle while the output is not stalled; the core state updates as the event result is registered.
// Reset: async active low; pipeline empty, light off, config at its defaults.
module backlight_timeout_fade_controller import btfc_pkg::*; #(
  parameter int unsigned MAX_BRIGHTNESS = 65535,
  parameter int unsigned ALS_DEPTH      = 5,
  parameter int unsigned FADE_STEPS     = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  req_type_i,
  input  logic        flag_bit_i,
  input  logic [15:0] als_level_i,
  input  logic        is_bright_i,
  input  logic        power_save_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] level_o,
  output logic [6:0]  level_pct_o,
  output logic [1:0]  mode_o
);

  cfg_t       cfg_q;
  req_t       in_q;
  logic       in_v_q;
  res_t       mid_q;
  logic       mid_v_q;
  res_t       out_q;
  logic [6:0] pct_q;
  logic       out_v_q;

  logic       rdy0, rdy1, rdy2;
  logic       adv;
  res_t       core_res;
  logic [6:0] pct;

  assign rdy2 = !out_v_q || !out_stall_i;
  assign rdy1 = !mid_v_q || rdy2;
  assign rdy0 = !in_v_q || rdy1;
  assign adv  = in_v_q && rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.user_level <= 16'd65535;
      cfg_q.timeout_ms <= 16'd3000;
      cfg_q.dynamic_on <= 1'b0;
      cfg_q.dark_limit <= 16'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_USER_LEVEL: cfg_q.user_level <= cfg_data_i;
        CFG_TIMEOUT_MS: cfg_q.timeout_ms <= cfg_data_i;
        CFG_DYNAMIC_ON: cfg_q.dynamic_on <= cfg_data_i[0];
        default:        cfg_q.dark_limit <= cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      mid_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (rdy0) in_v_q  <= in_valid_i;
      if (rdy1) mid_v_q <= in_v_q;
      if (rdy2) out_v_q <= mid_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy0 && in_valid_i) begin
      in_q.req_type   <= req_type_i;
      in_q.flag_bit   <= flag_bit_i;
      in_q.als_level  <= als_level_i;
      in_q.is_bright  <= is_bright_i;
      in_q.power_save <= power_save_i;
    end
    if (adv) begin
      mid_q <= core_res;
    end
    if (rdy2 && mid_v_q) begin
      out_q <= mid_q;
      pct_q <= pct;
    end
  end

  btfc_core #(
    .MAX_BRIGHTNESS(MAX_BRIGHTNESS),
    .ALS_DEPTH     (ALS_DEPTH),
    .FADE_STEPS    (FADE_STEPS)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .adv_i (adv),
    .req_i (in_q),
    .cfg_i (cfg_q),
    .res_o (core_res)
  );

  btfc_pct #(
    .MAX_BRIGHTNESS(MAX_BRIGHTNESS)
  ) u_pct (
    .level_i(mid_q.level),
    .pct_o  (pct)
  );

  assign in_stall_o  = !rdy0;
  assign out_valid_o = out_v_q;
  assign level_o     = out_q.level;
  assign level_pct_o = pct_q;
  assign mode_o      = out_q.mode;

  // stall upstream only when every stage is full and the output is held
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && mid_v_q && in_v_q))
    else $error("input stalled with a free pipeline stage");

  a_off_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (mode_o == MODE_OFF)) |-> (level_o == 16'd0))
    else $error("light off with nonzero level");

  a_fade_lit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (mode_o == MODE_FADING)) |-> (level_o != 16'd0))
    else $error("fading with zero level");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (level_pct_o <= 7'd100))
    else $error("percent above full scale");

endmodule

// ===== rtl/btfc_core.sv =====
// Event state machine: mode, level, countdown, button count and ambient ring.
// Uses btfc_pkg; state advances on adv_i, res_o is the state after the event.
module btfc_core import btfc_pkg::*; #(
  parameter int unsigned MAX_BRIGHTNESS = 65535,
  parameter int unsigned ALS_DEPTH      = 5,
  parameter int unsigned FADE_STEPS     = 20
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic adv_i,
  input  req_t req_i,
  input  cfg_t cfg_i,
  output res_t res_o
);

  localparam int unsigned AIW = (ALS_DEPTH > 1) ? $clog2(ALS_DEPTH) : 1;
  localparam int unsigned ACW = $clog2(ALS_DEPTH + 1);

  localparam logic [15:0] LEVEL_MAX  = 16'(MAX_BRIGHTNESS);
  localparam logic [15:0] LEVEL_LP   = 16'((MAX_BRIGHTNESS * 25) / 100);
  localparam logic [15:0] LEVEL_DARK = 16'((MAX_BRIGHTNESS * 10) / 100);
  localparam int unsigned PER_RAW    = 500 / FADE_STEPS;
  localparam logic [15:0] FADE_PER   = 16'((PER_RAW == 0) ? 1 : PER_RAW);
  localparam logic [2:0]  BTN_MAX    = 3'd4;

  // level / FADE_STEPS by exact reciprocal multiply
  localparam int unsigned FS_L  = $clog2(FADE_STEPS);
  localparam int unsigned FS_SH = 16 + FS_L;
  localparam int unsigned FS_MW = FS_SH + 1;
  localparam int unsigned FS_PW = 16 + FS_MW;
  localparam longint unsigned FS_RECIP_L =
    ((64'd1 << FS_SH) + 64'(FADE_STEPS) - 64'd1) / 64'(FADE_STEPS);
  localparam logic [FS_MW-1:0] FS_RECIP = FS_MW'(FS_RECIP_L);

  logic [1:0]     mode_q, mode_d;
  logic [15:0]    level_q, level_d;
  logic [15:0]    wait_q, wait_d;
  logic [2:0]     held_q, held_d;
  logic           forced_q, forced_d;
  logic           permit_q, permit_d;
  logic           sw_q, sw_d;
  logic           amb_q, amb_d;
  logic [15:0]    fdec_q, fdec_d;
  logic [ACW-1:0] filled_q, filled_d;
  logic [AIW-1:0] next_q, next_d;
  logic [15:0]    samp_q [ALS_DEPTH];

  logic           samp_we;
  logic           go_en;
  logic [1:0]     go_sel;
  logic           ml;
  logic           dark;
  logic [15:0]    tgt;
  logic [2:0]     held_dec;
  logic [FS_PW-1:0] fs_prod;
  logic [15:0]    step_raw;
  logic [15:0]    step;

  function automatic logic may_fn(input logic permit, input logic sw, input logic amb,
                                  input logic bright, input logic [15:0] lvl);
    return permit && sw && !(amb && (lvl == 16'd0) && bright);
  endfunction

  // dark only when every held sample is at or below the limit
  always_comb begin
    dark = 1'b1;
    for (int i = 0; i < ALS_DEPTH; i++) begin
      if ((ACW'(i) < filled_q) && (samp_q[i] > cfg_i.dark_limit)) begin
        dark = 1'b0;
      end
    end
  end

  always_comb begin
    if (req_i.power_save) begin
      tgt = LEVEL_LP;
    end else if (cfg_i.dynamic_on && (filled_q != '0) && dark) begin
      tgt = LEVEL_DARK;
    end else if (cfg_i.user_level > LEVEL_MAX) begin
      tgt = LEVEL_MAX;
    end else begin
      tgt = cfg_i.user_level;
    end
  end

  assign fs_prod  = FS_PW'(level_q) * FS_PW'(FS_RECIP);
  assign step_raw = fs_prod[FS_SH +: 16];
  // step is latched on fade entry and held for the rest of the fade
  assign step     = (mode_q != MODE_FADING) ?
                    ((step_raw == 16'd0) ? 16'd1 : step_raw) : fdec_q;

  assign ml       = may_fn(permit_q, sw_q, amb_q, req_i.is_bright, level_q);
  assign held_dec = (held_q != 3'd0) ? held_q - 3'd1 : 3'd0;

  always_comb begin
    held_d   = held_q;
    forced_d = forced_q;
    permit_d = permit_q;
    sw_d     = sw_q;
    amb_d    = amb_q;
    filled_d = filled_q;
    next_d   = next_q;
    wait_d   = wait_q;
    samp_we  = 1'b0;
    go_en    = 1'b0;
    go_sel   = MODE_OFF;

    unique case (req_i.req_type)
      REQ_PRESS: begin
        held_d = (held_q == BTN_MAX) ? 3'd0 : held_q + 3'd1;
        if (ml) begin
          go_en  = 1'b1;
          go_sel = MODE_ON;
        end
      end
      REQ_RELEASE: begin
        held_d = held_dec;
        if ((held_dec == 3'd0) && (mode_q == MODE_ON) && !forced_q) begin
          go_en  = 1'b1;
          go_sel = MODE_TIMED;
        end
      end
      REQ_INTERACT: begin
        if ((held_q == 3'd0) && (mode_q != MODE_ON) && ml) begin
          go_en  = 1'b1;
          go_sel = MODE_TIMED;
        end
      end
      REQ_FORCE: begin
        forced_d = req_i.flag_bit;
        if (req_i.flag_bit) begin
          go_en  = 1'b1;
          go_sel = MODE_ON;
        end else if (held_q == 3'd0) begin
          go_en  = 1'b1;
          go_sel = MODE_OFF;
        end
      end
      REQ_RESPECT: begin
        forced_d = req_i.flag_bit;
        if (req_i.flag_bit) begin
          if (ml) begin
            go_en  = 1'b1;
            go_sel = MODE_ON;
          end
        end else if (held_q == 3'd0) begin
          go_en  = 1'b1;
          go_sel = MODE_OFF;
        end
      end
      REQ_RST_USER: begin
        if (forced_q) begin
          forced_d = 1'b0;
          if (held_q == 3'd0) begin
            go_en  = 1'b1;
            go_sel = MODE_OFF;
          end
        end
      end
      REQ_RST_TIMED: begin
        if (forced_q) begin
          forced_d = 1'b0;
          if (ml) begin
            go_en  = 1'b1;
            go_sel = MODE_TIMED;
          end
        end
      end
      REQ_TGL_EN: begin
        sw_d   = !sw_q;
        go_en  = 1'b1;
        go_sel = may_fn(permit_q, !sw_q, amb_q, req_i.is_bright, level_q) ?
                 MODE_TIMED : MODE_OFF;
      end
      REQ_TGL_AMB: begin
        amb_d  = !amb_q;
        go_en  = 1'b1;
        go_sel = (may_fn(permit_q, sw_q, !amb_q, req_i.is_bright, level_q) &&
                  !req_i.is_bright) ? MODE_TIMED : MODE_OFF;
      end
      REQ_PERMIT: begin
        permit_d = req_i.flag_bit;
        if (permit_q && !req_i.flag_bit) begin
          go_en  = 1'b1;
          go_sel = MODE_OFF;
        end
      end
      REQ_TICK: begin
        if ((mode_q == MODE_TIMED) || (mode_q == MODE_FADING)) begin
          if (wait_q <= 16'd1) begin
            go_en  = 1'b1;
            go_sel = MODE_FADING;
          end else begin
            wait_d = wait_q - 16'd1;
          end
        end
      end
      REQ_SAMPLE: begin
        samp_we = 1'b1;
        next_d  = (next_q == AIW'(ALS_DEPTH - 1)) ? '0 : next_q + AIW'(1);
        if (filled_q < ACW'(ALS_DEPTH)) begin
          filled_d = filled_q + ACW'(1);
        end
      end
      default: ;
    endcase

    mode_d  = mode_q;
    level_d = level_q;
    fdec_d  = fdec_q;
    if (go_en) begin
      unique case (go_sel)
        MODE_ON: begin
          mode_d  = MODE_ON;
          level_d = tgt;
          wait_d  = 16'd0;
        end
        MODE_TIMED: begin
          mode_d  = MODE_TIMED;
          level_d = tgt;
          wait_d  = cfg_i.timeout_ms;
        end
        MODE_FADING: begin
          fdec_d = step;
          if (level_q <= step) begin
            mode_d  = MODE_OFF;
            level_d = 16'd0;
            wait_d  = 16'd0;
          end else begin
            mode_d  = MODE_FADING;
            level_d = level_q - step;
            wait_d  = FADE_PER;
          end
        end
        default: begin
          mode_d  = MODE_OFF;
          level_d = 16'd0;
          wait_d  = 16'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_OFF;
      level_q  <= 16'd0;
      wait_q   <= 16'd0;
      held_q   <= 3'd0;
      forced_q <= 1'b0;
      permit_q <= 1'b0;
      sw_q     <= 1'b1;
      amb_q    <= 1'b0;
      fdec_q   <= 16'd0;
      filled_q <= '0;
      next_q   <= '0;
    end else if (adv_i) begin
      mode_q   <= mode_d;
      level_q  <= level_d;
      wait_q   <= wait_d;
      held_q   <= held_d;
      forced_q <= forced_d;
      permit_q <= permit_d;
      sw_q     <= sw_d;
      amb_q    <= amb_d;
      fdec_q   <= fdec_d;
      filled_q <= filled_d;
      next_q   <= next_d;
    end
  end

  // entries past the fill count are never read, so no reset here
  always_ff @(posedge clk_i) begin
    if (adv_i && samp_we) begin
      samp_q[next_q] <= req_i.als_level;
    end
  end

  assign res_o.level = level_d;
  assign res_o.mode  = mode_d;

endmodule

// ===== rtl/btfc_pct.sv =====
// Level to percent of full scale: level*100/MAX_BRIGHTNESS, truncated.
// Exact reciprocal multiply; no package dependency.
module btfc_pct #(
  parameter int unsigned MAX_BRIGHTNESS = 65535
) (
  input  logic [15:0] level_i,
  output logic [6:0]  pct_o
);

  localparam int unsigned PL  = $clog2(MAX_BRIGHTNESS);
  localparam int unsigned PSH = 23 + PL;
  localparam int unsigned PMW = 25;
  localparam longint unsigned PM_L =
    ((64'd1 << PSH) + 64'(MAX_BRIGHTNESS) - 64'd1) / 64'(MAX_BRIGHTNESS);
  localparam logic [PMW-1:0] PM = PMW'(PM_L);

  logic [22:0] lv;
  logic [22:0] x100;
  logic [47:0] prod;

  assign lv    = 23'(level_i);
  assign x100  = (lv << 6) + (lv << 5) + (lv << 2);
  assign prod  = 48'(x100) * 48'(PM);
  assign pct_o = prod[PSH +: 7];

endmodule

// ===== verif/tb_backlight_timeout_fade_controller.sv =====
// Testbench for backlight_timeout_fade_controller: directed event checks, full fades,
// random traffic under several settings, and output back-pressure.
// Depends on rtl/btfc_pkg.sv and rtl/backlight_timeout_fade_controller.sv.
module tb_backlight_timeout_fade_controller;
  import btfc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_BRI      = 65535;
  localparam int unsigned ALS_DEPTH    = 5;
  localparam int unsigned FADE_STEPS   = 20;
  localparam int unsigned FADE_MS      = 500;
  localparam int unsigned FADE_PERIOD  = (FADE_MS / FADE_STEPS) > 0 ? FADE_MS / FADE_STEPS : 1;
  localparam int unsigned LP_LEVEL     = (MAX_BRI * 25) / 100;
  localparam int unsigned DARK_LEVEL   = (MAX_BRI * 10) / 100;
  localparam int          DRAIN        = 8;
  localparam int          LIMIT_CYCLES = 1000000;
  localparam int          HOLD_CYCLES  = 150;

  typedef struct packed {
    logic [15:0] level;
    logic [6:0]  pct;
    logic [1:0]  mode;
  } lamp_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = CFG_USER_LEVEL;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  req_type = REQ_TICK;
  logic        flag_bit = 1'b0;
  logic [15:0] als_level = '0;
  logic        is_bright = 1'b0;
  logic        power_save = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] level;
  logic [6:0]  level_pct;
  logic [1:0]  mode;

  backlight_timeout_fade_controller DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .req_type_i  (req_type),
    .flag_bit_i  (flag_bit),
    .als_level_i (als_level),
    .is_bright_i (is_bright),
    .power_save_i(power_save),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .level_o     (level),
    .level_pct_o (level_pct),
    .mode_o      (mode)
  );

  // shadow of the controller: settings and state
  logic [15:0] cfg_user    = 16'd65535;
  logic [15:0] cfg_timeout = 16'd3000;
  logic        cfg_dyn     = 1'b0;
  logic [15:0] cfg_dark    = 16'd0;

  logic [1:0]  mode_q     = MODE_OFF;
  logic [15:0] lvl        = '0;
  logic [15:0] wait_cnt   = '0;
  logic [2:0]  held       = '0;
  logic        forced     = 1'b0;
  logic        permitted  = 1'b0;
  logic        switch_on  = 1'b1;
  logic        amb_check  = 1'b0;
  logic [15:0] fade_start = '0;
  logic [15:0] fade_dec   = '0;
  logic [15:0] samples [ALS_DEPTH] = '{default: '0};
  int unsigned filled     = 0;
  int unsigned next_slot  = 0;

  lamp_t lamp_q[$];
  int    errors    = 0;
  bit    calm      = 1'b0;
  int    hold_reqs = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned target_for(logic lp);
    int unsigned v;
    bit          dark;
    if (lp) return LP_LEVEL;
    v = cfg_user;
    if (cfg_dyn && filled > 0) begin
      dark = 1'b1;
      for (int i = 0; i < filled && i < ALS_DEPTH; i++)
        if (samples[i] > cfg_dark) dark = 1'b0;
      if (dark) v = DARK_LEVEL;
    end
    if (v > MAX_BRI) v = MAX_BRI;
    return v;
  endfunction

  function automatic bit light_ok(logic bright);
    if (!permitted || !switch_on) return 1'b0;
    // ambient check only blocks turning on from dark
    if (amb_check && lvl == 0 && bright) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void enter_mode(logic [1:0] nxt, logic lp);
    logic [1:0] prev;
    prev   = mode_q;
    mode_q = nxt;
    case (nxt)
      MODE_ON: begin
        lvl      = 16'(target_for(lp));
        wait_cnt = '0;
      end
      MODE_TIMED: begin
        lvl      = 16'(target_for(lp));
        wait_cnt = cfg_timeout;
      end
      MODE_FADING: begin
        if (prev != MODE_FADING) begin
          fade_start = lvl;
          fade_dec   = 16'(fade_start / FADE_STEPS);
          if (fade_dec == 0) fade_dec = 16'd1;
        end
        if (lvl <= fade_dec) begin
          lvl      = '0;
          mode_q   = MODE_OFF;
          wait_cnt = '0;
        end else begin
          lvl      = lvl - fade_dec;
          wait_cnt = 16'(FADE_PERIOD);
        end
      end
      default: begin
        lvl      = '0;
        wait_cnt = '0;
      end
    endcase
  endfunction

  function automatic void step_backlight(logic [3:0] kind, logic flag, logic [15:0] als,
                                         logic bright, logic lp);
    lamp_t res;
    case (kind)
      REQ_PRESS: begin
        held = (held == 3'd4) ? 3'd0 : held + 3'd1;
        if (light_ok(bright)) enter_mode(MODE_ON, lp);
      end
      REQ_RELEASE: begin
        if (held != 0) held = held - 3'd1;
        if (held == 0 && mode_q == MODE_ON && !forced) enter_mode(MODE_TIMED, lp);
      end
      REQ_INTERACT: begin
        if (held == 0 && mode_q != MODE_ON && light_ok(bright)) enter_mode(MODE_TIMED, lp);
      end
      REQ_FORCE: begin
        forced = flag;
        if (flag) enter_mode(MODE_ON, lp);
        else if (held == 0) enter_mode(MODE_OFF, lp);
      end
      REQ_RESPECT: begin
        forced = flag;
        if (flag) begin
          if (light_ok(bright)) enter_mode(MODE_ON, lp);
        end else if (held == 0) begin
          enter_mode(MODE_OFF, lp);
        end
      end
      REQ_RST_USER: begin
        if (forced) begin
          forced = 1'b0;
          if (held == 0) enter_mode(MODE_OFF, lp);
        end
      end
      REQ_RST_TIMED: begin
        if (forced) begin
          forced = 1'b0;
          if (light_ok(bright)) enter_mode(MODE_TIMED, lp);
        end
      end
      REQ_TGL_EN: begin
        switch_on = !switch_on;
        enter_mode(light_ok(bright) ? MODE_TIMED : MODE_OFF, lp);
      end
      REQ_TGL_AMB: begin
        amb_check = !amb_check;
        enter_mode((light_ok(bright) && !bright) ? MODE_TIMED : MODE_OFF, lp);
      end
      REQ_PERMIT: begin
        if (permitted && !flag) enter_mode(MODE_OFF, lp);
        permitted = flag;
      end
      REQ_TICK: begin
        if (mode_q == MODE_TIMED || mode_q == MODE_FADING) begin
          if (wait_cnt <= 1) enter_mode(MODE_FADING, lp);
          else wait_cnt = wait_cnt - 16'd1;
        end
      end
      REQ_SAMPLE: begin
        samples[next_slot] = als;
        next_slot = (next_slot + 1 >= ALS_DEPTH) ? 0 : next_slot + 1;
        if (filled < ALS_DEPTH) filled++;
      end
      default: ;
    endcase
    res.level = lvl;
    res.pct   = 7'((32'(lvl) * 100) / MAX_BRI);
    res.mode  = mode_q;
    lamp_q.push_back(res);
  endfunction

  // offer one word, wait for it to be taken, then maybe leave a gap
  task automatic send_word(input logic [3:0] kind, input logic flag, input logic [15:0] als,
                           input logic bright, input logic lp);
    int r;
    int gap;
    in_valid   <= 1'b1;
    req_type   <= kind;
    flag_bit   <= flag;
    als_level  <= als;
    is_bright  <= bright;
    power_save <= lp;
    do @(posedge clk); while (in_stall);
    step_backlight(kind, flag, als, bright, lp);
    r = $urandom_range(0, 99);
    if (calm || r < 60) gap = 0;
    else if (r < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(6, 30);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (lamp_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic load_settings(input logic [15:0] user, input logic [15:0] timeout,
                               input logic dyn, input logic [15:0] dark);
    settle();
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_USER_LEVEL;
    cfg_data <= user;
    @(posedge clk);
    cfg_idx  <= CFG_TIMEOUT_MS;
    cfg_data <= timeout;
    @(posedge clk);
    cfg_idx  <= CFG_DYNAMIC_ON;
    cfg_data <= {15'd0, dyn};
    @(posedge clk);
    cfg_idx  <= CFG_DARK_LIMIT;
    cfg_data <= dark;
    @(posedge clk);
    cfg_we      <= 1'b0;
    cfg_user    = user;
    cfg_timeout = timeout;
    cfg_dyn     = dyn;
    cfg_dark    = dark;
  endtask

  function automatic logic [3:0] pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return REQ_TICK;
    if (r < 37) return REQ_PRESS;
    if (r < 49) return REQ_RELEASE;
    if (r < 59) return REQ_INTERACT;
    if (r < 67) return REQ_SAMPLE;
    if (r < 70) return REQ_FORCE;
    if (r < 73) return REQ_RESPECT;
    if (r < 76) return REQ_RST_USER;
    if (r < 79) return REQ_RST_TIMED;
    if (r < 83) return REQ_TGL_EN;
    if (r < 87) return REQ_TGL_AMB;
    if (r < 94) return REQ_PERMIT;
    return 4'($urandom_range(15, int'(REQ_SAMPLE) + 1));
  endfunction

  task automatic send_random();
    logic [15:0] als;
    if ($urandom_range(0, 1)) als = 16'($urandom_range(0, cfg_dark));
    else als = 16'($urandom_range(0, 65535));
    send_word(pick_kind(), $urandom_range(0, 9) < 7, als,
              $urandom_range(0, 9) < 3, $urandom_range(0, 3) == 0);
  endtask

  // light it up from a known idle point, then tick until the fade ends
  task automatic run_fade(input logic lp);
    int guard;
    while (held != 0) send_word(REQ_RELEASE, 1'b0, 16'd0, 1'b0, lp);
    send_word(REQ_FORCE, 1'b0, 16'hFFFF, 1'b1, lp);
    if (!permitted) send_word(REQ_PERMIT, 1'b1, 16'd0, 1'b0, lp);
    if (!switch_on) send_word(REQ_TGL_EN, 1'b0, 16'd0, 1'b0, lp);
    send_word(REQ_INTERACT, 1'b0, 16'd0, 1'b0, lp);
    guard = 0;
    while (mode_q != MODE_OFF && guard < 2000) begin
      if ($urandom_range(0, 19) == 0)
        send_word($urandom_range(0, 1) ? REQ_SAMPLE :
                  4'($urandom_range(15, int'(REQ_SAMPLE) + 1)),
                  $urandom_range(0, 1), 16'($urandom_range(0, cfg_dark)),
                  $urandom_range(0, 1), $urandom_range(0, 1));
      else
        send_word(REQ_TICK, $urandom_range(0, 1), 16'($urandom_range(0, 65535)),
                  $urandom_range(0, 1), $urandom_range(0, 1));
      guard++;
    end
  endtask

  task automatic test_directed_events();
    send_word(REQ_SAMPLE + 4'd1, 1'b1, 16'hFFFF, 1'b1, 1'b1); // unknown code, nothing moves
    send_word(REQ_INTERACT, 1'b0, 16'd0, 1'b0, 1'b0);      // not permitted yet
    send_word(REQ_PERMIT, 1'b1, 16'd0, 1'b0, 1'b0);
    send_word(REQ_PRESS, 1'b0, 16'd0, 1'b1, 1'b1);         // low power level
    repeat (4) send_word(REQ_PRESS, 1'b0, 16'd0, 1'b0, 1'b0); // fifth press wraps count
    send_word(REQ_RELEASE, 1'b0, 16'd0, 1'b0, 1'b0);       // nothing held, count stays 0
    send_word(REQ_FORCE, 1'b1, 16'd0, 1'b0, 1'b1);
    send_word(REQ_RELEASE, 1'b0, 16'd0, 1'b0, 1'b0);       // forced, stays on
    send_word(REQ_RST_TIMED, 1'b0, 16'd0, 1'b0, 1'b0);
    send_word(REQ_FORCE, 1'b1, 16'd0, 1'b0, 1'b0);
    send_word(REQ_RST_USER, 1'b0, 16'd0, 1'b0, 1'b0);
    send_word(REQ_RESPECT, 1'b1, 16'd0, 1'b0, 1'b1);
    send_word(REQ_RESPECT, 1'b0, 16'd0, 1'b0, 1'b0);
    send_word(REQ_TGL_AMB, 1'b0, 16'd0, 1'b0, 1'b0);
    send_word(REQ_TGL_EN, 1'b0, 16'd0, 1'b0, 1'b0);        // switch off
    send_word(REQ_TGL_EN, 1'b0, 16'd0, 1'b1, 1'b0);        // dark and bright: blocked
    send_word(REQ_INTERACT, 1'b0, 16'd0, 1'b1, 1'b0);
    send_word(REQ_INTERACT, 1'b0, 16'd0, 1'b0, 1'b0);
    send_word(REQ_SAMPLE, 1'b0, 16'hFFFF, 1'b0, 1'b0);
    send_word(REQ_SAMPLE, 1'b1, 16'h0000, 1'b1, 1'b1);
    send_word(REQ_TICK, 1'b0, 16'd0, 1'b0, 1'b0);
    send_word(REQ_PERMIT, 1'b0, 16'd0, 1'b0, 1'b0);
    send_word(REQ_TICK, 1'b1, 16'hFFFF, 1'b1, 1'b1);
  endtask

  task automatic test_low_power_fade();
    load_settings(16'd65535, 16'd0, 1'b0, 16'd0);
    run_fade(1'b1);
  endtask

  task automatic test_dark_fade();
    load_settings(16'd40000, 16'd7, 1'b1, 16'd1000);
    send_word(REQ_SAMPLE, 1'b0, 16'd1000, 1'b0, 1'b0);     // exactly at the limit
    repeat (6) send_word(REQ_SAMPLE, 1'b0, 16'($urandom_range(0, 1000)), 1'b0, 1'b0);
    run_fade(1'b0);
  endtask

  task automatic test_mixed_traffic(input int n);
    repeat (n) send_random();
  endtask

  task automatic test_output_backpressure();
    settle();
    calm = 1'b1;
    hold_reqs++;
    repeat (60) send_random();
    calm = 1'b0;
  endtask

  // receiver pacing: free runs, short stalls, a few long ones
  initial begin : rx_pacing
    int   run;
    int   r;
    int   hold_left;
    int   hold_seen;
    logic stall_now;
    run       = 0;
    hold_left = 0;
    hold_seen = 0;
    stall_now = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        if (run == 0) begin
          r = $urandom_range(0, 99);
          if (r < 45) begin
            stall_now = 1'b0;
            run = $urandom_range(1, 40);
          end else if (r < 90) begin
            stall_now = 1'b1;
            run = $urandom_range(1, 3);
          end else begin
            stall_now = 1'b1;
            run = $urandom_range(8, 40);
          end
        end
        out_stall <= stall_now;
        run--;
      end
    end
  end

  always @(posedge clk) begin
    lamp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (lamp_q.size() == 0) begin
        $error("unexpected word: level %0d pct %0d mode %0d", level, level_pct, mode);
        errors++;
      end else begin
        want = lamp_q.pop_front();
        if (level !== want.level) begin
          $error("level: expected %0d, got %0d", want.level, level);
          errors++;
        end
        if (level_pct !== want.pct) begin
          $error("level_pct: expected %0d, got %0d", want.pct, level_pct);
          errors++;
        end
        if (mode !== want.mode) begin
          $error("mode: expected %0d, got %0d", want.mode, mode);
          errors++;
        end
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("backlight_timeout_fade_controller verification failed");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_events();
    test_low_power_fade();
    test_dark_fade();
    load_settings(16'd0, 16'd65535, 1'b0, 16'd65535);
    test_mixed_traffic(130);
    load_settings(16'd12345, 16'd30, 1'b1, 16'd65535);
    test_mixed_traffic(130);
    load_settings(16'd50000, 16'd3, 1'b1, 16'd0);
    test_mixed_traffic(130);
    test_output_backpressure();
    load_settings(16'd65535, 16'd12, 1'b0, 16'd20000);
    test_mixed_traffic(130);
    settle();
    if (errors == 0 && lamp_q.size() == 0) begin
      $display("backlight_timeout_fade_controller verification clean");
    end else begin
      $display("backlight_timeout_fade_controller verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/btfc_pkg.sv
rtl/btfc_core.sv
rtl/btfc_pct.sv
rtl/backlight_timeout_fade_controller.sv
verif/tb_backlight_timeout_fade_controller.sv
